// File: rtl/bsra_pkg.sv
// ----------------------------------------------------------------------------
// Bump-and-slot region allocator package
// Widths, request and status codes, a shared type and a helper function.
// ----------------------------------------------------------------------------
package bsra_pkg;

   localparam int unsigned REQ_W    = 2;
   localparam int unsigned SIZE_W   = 41;
   localparam int unsigned OFFS_W   = 40;
   localparam int unsigned ALIGN_W  = 6;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W   = 6;

   localparam int unsigned MAX_SLOTS_DEF   = 64;
   localparam int unsigned SLOT_MAP_W      = 64;
   localparam int unsigned SLOT_SIZE_LOG2  = 21;
   localparam int unsigned BASE_ALIGN_LOG2 = 21;
   localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 6'd40;

   localparam logic [REQ_W-1:0] REQ_EARLY_ALLOC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SET_BASE    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SLOT_ALLOC  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_SLOT_FREE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_BASE    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_DOUBLE     = 3'd7;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } pick_type;

   // Bit p of the mask is set when bit b of the position p is set.
   function automatic logic [SLOT_MAP_W-1:0] index_bit_mask(input int unsigned bit_pos);
      logic [SLOT_MAP_W-1:0] mask;
      mask = '0;
      for (int unsigned p = 0; p < SLOT_MAP_W; p++) begin
         mask[p] = ((p >> bit_pos) & 1) != 0;
      end
      return mask;
   endfunction

endpackage

// File: rtl/bsra_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocator request item.
// ----------------------------------------------------------------------------
interface bsra_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsra_pkg::REQ_W-1:0]     req_type;
   logic [bsra_pkg::SIZE_W-1:0]    alloc_size;
   logic [bsra_pkg::ALIGN_W-1:0]   align_log2;
   logic [bsra_pkg::OFFS_W-1:0]    region_offset;

   modport source (
      output valid, req_type, alloc_size, align_log2, region_offset,
      input  ready
   );
   modport sink (
      input  valid, req_type, alloc_size, align_log2, region_offset,
      output ready
   );
endinterface

// File: rtl/bsra_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one allocator result item.
// ----------------------------------------------------------------------------
interface bsra_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsra_pkg::STATUS_W-1:0]  status;
   logic [bsra_pkg::OFFS_W-1:0]    result_offset;
   logic [bsra_pkg::SLOT_W-1:0]    slot_index;

   modport source (
      output valid, status, result_offset, slot_index,
      input  ready
   );
   modport sink (
      input  valid, status, result_offset, slot_index,
      output ready
   );
endinterface

// File: rtl/bsra_slot_pick.sv
// ----------------------------------------------------------------------------
// Lowest free slot picker
// Finds the lowest set bit of the free map and encodes its position.
// ----------------------------------------------------------------------------
module bsra_slot_pick #(
   parameter int unsigned MAX_SLOTS = bsra_pkg::MAX_SLOTS_DEF
) (
   input  logic [MAX_SLOTS-1:0] free_map,
   output bsra_pkg::pick_type   pick
);

   logic [bsra_pkg::SLOT_MAP_W-1:0] avail;
   logic [bsra_pkg::SLOT_MAP_W-1:0] lowest;

   // Two's complement trick isolates the lowest set bit as a one-hot word.
   assign avail  = bsra_pkg::SLOT_MAP_W'(free_map);
   assign lowest = avail & (~avail + bsra_pkg::SLOT_MAP_W'(1));

   always_comb begin
      pick.found = |avail;
      for (int unsigned b = 0; b < bsra_pkg::SLOT_W; b++) begin
         pick.index[b] = |(lowest & bsra_pkg::index_bit_mask(b));
      end
   end

endmodule

// File: rtl/bump_and_slot_region_allocator_top.sv
// ----------------------------------------------------------------------------
// Bump-and-slot region allocator
// Early bump allocation, client base setup and slot allocate/free by offset.
// ----------------------------------------------------------------------------
// One item is accepted per clock. The request register takes the item at the
// accepting edge, with the size already rounded to the alignment. When the
// item advances, it is evaluated against the allocator state, that state is
// updated and the result register is loaded, which then offers the result.
// The state update is made together with the evaluation, so back-to-back
// requests see each other's effects. Sustained rate is one item per cycle
// while the result side keeps taking items; while a result waits, one more
// item is held in the request register and the input then stalls until the
// result is taken. A request that fails leaves all state unchanged.
// region_size must only be written while no request is in flight.
// ----------------------------------------------------------------------------
module bump_and_slot_region_allocator_top #(
   parameter int unsigned MAX_SLOTS = bsra_pkg::MAX_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bsra_req_if.sink                      req_ch,
   bsra_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bsra_pkg::SIZE_W-1:0]   csr_wr_data
);

   localparam int unsigned START_W = bsra_pkg::SIZE_W + 1;
   localparam int unsigned STOP_W  = bsra_pkg::SIZE_W + 2;

   // Configuration and allocator state.
   logic [bsra_pkg::SIZE_W-1:0]     region_size_ff;
   logic [bsra_pkg::SIZE_W-1:0]     bump_ff, bump_in;
   logic [bsra_pkg::OFFS_W-1:0]     base_ff, base_in;
   logic                            base_valid_ff, base_valid_in;
   logic [MAX_SLOTS-1:0]            map_ff, map_in;

   // Request register.
   logic                            s1_valid_ff, s1_valid_in;
   logic [bsra_pkg::REQ_W-1:0]      s1_type_ff;
   logic [bsra_pkg::OFFS_W-1:0]     s1_offset_ff;
   logic [bsra_pkg::OFFS_W-1:0]     s1_mask_ff;
   logic [START_W-1:0]              s1_size_ff;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bsra_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [bsra_pkg::OFFS_W-1:0]     rsp_offset_ff;
   logic [bsra_pkg::SLOT_W-1:0]     rsp_slot_ff;

   logic                            req_accept;
   logic                            s1_adv;
   logic [bsra_pkg::ALIGN_W-1:0]    lg_clamp;
   logic [bsra_pkg::OFFS_W-1:0]     align_mask;
   logic [START_W-1:0]              size_rnd;

   logic [bsra_pkg::SLOT_MAP_W-1:0] map_pad;
   logic [bsra_pkg::SLOT_MAP_W-1:0] map_pad_in;
   bsra_pkg::pick_type              pick;

   logic [bsra_pkg::STATUS_W-1:0]   status_in;
   logic [bsra_pkg::OFFS_W-1:0]     offset_in;
   logic [bsra_pkg::SLOT_W-1:0]     slot_in;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_offset = rsp_offset_ff;
   assign rsp_ch.slot_index    = rsp_slot_ff;

   // ------------------------------------------------------------------------
   // Request decode: alignment mask and rounded size
   // ------------------------------------------------------------------------
   assign lg_clamp   = (req_ch.align_log2 > bsra_pkg::MAX_ALIGN_LOG2) ?
                       bsra_pkg::MAX_ALIGN_LOG2 : req_ch.align_log2;
   assign align_mask = ~({bsra_pkg::OFFS_W{1'b1}} << lg_clamp);
   // The start offset is aligned, so rounding the end equals adding the
   // rounded size to the start.
   assign size_rnd   = (START_W'(req_ch.alloc_size) + START_W'(align_mask))
                       & ~START_W'(align_mask);

   // ------------------------------------------------------------------------
   // Evaluation
   // ------------------------------------------------------------------------
   assign map_pad = bsra_pkg::SLOT_MAP_W'(map_ff);

   bsra_slot_pick #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_slot_pick (
      .free_map (map_ff),
      .pick     (pick)
   );

   always_comb begin
      logic [START_W-1:0]          start_sum;
      logic [START_W-1:0]          start_off;
      logic [STOP_W-1:0]           stop_off;
      logic [bsra_pkg::OFFS_W-1:0] diff;
      logic [bsra_pkg::OFFS_W-1:0] slot_num;

      start_sum = START_W'(bump_ff) + START_W'(s1_mask_ff);
      start_off = start_sum & ~START_W'(s1_mask_ff);
      stop_off  = STOP_W'(start_off) + STOP_W'(s1_size_ff);
      diff      = s1_offset_ff - base_ff;
      slot_num  = diff >> bsra_pkg::SLOT_SIZE_LOG2;

      status_in     = bsra_pkg::ST_OK;
      offset_in     = '0;
      slot_in       = '0;
      bump_in       = bump_ff;
      base_in       = base_ff;
      base_valid_in = base_valid_ff;
      map_pad_in    = map_pad;

      case (s1_type_ff)
         bsra_pkg::REQ_EARLY_ALLOC: begin
            if ((stop_off > STOP_W'(region_size_ff)) ||
                (start_off[START_W-1:bsra_pkg::OFFS_W] != '0)) begin
               status_in = bsra_pkg::ST_OVERFLOW;
            end else begin
               offset_in = start_off[bsra_pkg::OFFS_W-1:0];
               bump_in   = stop_off[bsra_pkg::SIZE_W-1:0];
            end
         end
         bsra_pkg::REQ_SET_BASE: begin
            if (s1_offset_ff[bsra_pkg::BASE_ALIGN_LOG2-1:0] != '0) begin
               status_in = bsra_pkg::ST_MISALIGNED;
            end else if (bsra_pkg::SIZE_W'(s1_offset_ff) >= bump_ff) begin
               status_in = bsra_pkg::ST_BEYOND;
            end else begin
               base_in       = s1_offset_ff;
               base_valid_in = 1'b1;
            end
         end
         bsra_pkg::REQ_SLOT_ALLOC: begin
            if (!base_valid_ff) begin
               status_in = bsra_pkg::ST_NO_BASE;
            end else if (!pick.found) begin
               status_in = bsra_pkg::ST_NO_SLOT;
            end else begin
               slot_in   = pick.index;
               offset_in = base_ff + (bsra_pkg::OFFS_W'(pick.index)
                                      << bsra_pkg::SLOT_SIZE_LOG2);
               map_pad_in[pick.index] = 1'b0;
            end
         end
         bsra_pkg::REQ_SLOT_FREE: begin
            if (!base_valid_ff) begin
               status_in = bsra_pkg::ST_NO_BASE;
            end else if ((s1_offset_ff < base_ff) ||
                         (slot_num >= bsra_pkg::OFFS_W'(MAX_SLOTS))) begin
               status_in = bsra_pkg::ST_BAD_FREE;
            end else if (map_pad[slot_num[bsra_pkg::SLOT_W-1:0]]) begin
               status_in = bsra_pkg::ST_DOUBLE;
               slot_in   = slot_num[bsra_pkg::SLOT_W-1:0];
            end else begin
               slot_in = slot_num[bsra_pkg::SLOT_W-1:0];
               map_pad_in[slot_num[bsra_pkg::SLOT_W-1:0]] = 1'b1;
            end
         end
         default: begin
            status_in = bsra_pkg::ST_OK;
         end
      endcase
   end

   assign map_in = map_pad_in[MAX_SLOTS-1:0];

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         region_size_ff <= '0;
         bump_ff        <= '0;
         base_ff        <= '0;
         base_valid_ff  <= 1'b0;
         map_ff         <= '1;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            region_size_ff <= csr_wr_data;
         end
         if (s1_adv) begin
            bump_ff       <= bump_in;
            base_ff       <= base_in;
            base_valid_ff <= base_valid_in;
            map_ff        <= map_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff   <= req_ch.req_type;
         s1_offset_ff <= req_ch.region_offset;
         s1_mask_ff   <= align_mask;
         s1_size_ff   <= size_rnd;
      end
      if (s1_adv) begin
         rsp_status_ff <= status_in;
         rsp_offset_ff <= offset_in;
         rsp_slot_ff   <= slot_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (status_in != bsra_pkg::ST_OK)) |=>
         ($stable(bump_ff) && $stable(base_ff) && $stable(base_valid_ff) &&
          $stable(map_ff)))
      else $error("failed request changed allocator state");

   a_alloc_clears_slot: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_type_ff == bsra_pkg::REQ_SLOT_ALLOC) &&
       (status_in == bsra_pkg::ST_OK)) |=>
         (map_pad[$past(pick.index)] == 1'b0))
      else $error("allocated slot still marked free");

   a_base_below_bump: assert property (@(posedge clock) disable iff (reset)
      base_valid_ff |-> (bsra_pkg::SIZE_W'(base_ff) < bump_ff))
      else $error("client base lies outside the early area");

   a_result_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && !s1_adv ||
                                           $stable(rsp_status_ff)))
      else $error("pending result overwritten");

endmodule
